// ===== hdl/cfq_pkg.sv =====
// cfq_pkg: request kinds, status codes, widths and the step record shared by
// the circular fifo queue modules. No dependencies.
`default_nettype none

package cfq_pkg;

   localparam int WORD_W = 32;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam int               CAP_MIN   = 2;

   localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RSV  = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic signed [WORD_W-1:0] NO_WORD = '1;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              is_read;
      logic              is_empty;
      logic              is_full;
   } cfq_step_type;

endpackage

`default_nettype wire

// ===== hdl/cfq_ram.sv =====
// cfq_ram: single-port slot memory, one write or one read per cycle,
// registered read data. Depends on cfq_pkg for the word width.
`default_nettype none

module cfq_ram
   import cfq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            addr,
   input  wire logic signed [WORD_W-1:0] wr_data,
   output logic signed [WORD_W-1:0]      rd_data
);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/cfq_ctrl.sv =====
// cfq_ctrl: head/tail pointers, empty mark and capacity register; decodes
// one request into memory access and status. Depends on cfq_pkg.
`default_nettype none

module cfq_ctrl
   import cfq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [CAP_W-1:0]  csr_wr_data,
   input  wire logic              fire,
   input  wire logic [KIND_W-1:0] kind,
   output logic                   ram_wr_en,
   output logic                   ram_rd_en,
   output logic [AW-1:0]          ram_addr,
   output cfq_step_type           step
);

   localparam int CW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [AW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic             none_ff, none_in;

   logic [CW-1:0]    cap_ext, cap_live;
   logic [AW-1:0]    step_head, step_tail;
   logic             step_none, full_now, do_wr, do_rd;
   logic [STAT_W-1:0] status;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                             input logic [CW-1:0] lim);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      return (nxt >= lim) ? '0 : idx + AW'(1);
   endfunction

   // capacity in use saturates into 2..DEPTH
   always_comb begin
      cap_ext = CW'(cap_ff);
      if (cap_ext < CW'(CAP_MIN)) begin
         cap_live = CW'(CAP_MIN);
      end else if (cap_ext > CW'(DEPTH)) begin
         cap_live = CW'(DEPTH);
      end else begin
         cap_live = cap_ext;
      end
   end

   always_comb begin
      full_now  = !none_ff && (head_ff == tail_ff);
      step_head = head_ff;
      step_tail = tail_ff;
      step_none = none_ff;
      status    = ST_OK;
      do_wr     = 1'b0;
      do_rd     = 1'b0;
      unique case (kind) inside
         KIND_ENQ: begin
            if (full_now) begin
               status = ST_FULL;
            end else begin
               do_wr     = 1'b1;
               step_tail = advance(tail_ff, cap_live);
               step_none = 1'b0;
            end
         end
         KIND_DEQ: begin
            if (none_ff) begin
               status = ST_EMPTY;
            end else begin
               do_rd     = 1'b1;
               step_head = advance(head_ff, cap_live);
               step_none = (step_head == tail_ff);
            end
         end
         KIND_PEEK, KIND_RSV: begin
            if (none_ff) begin
               status = ST_EMPTY;
            end else begin
               do_rd = 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign ram_wr_en     = fire && do_wr;
   assign ram_rd_en     = fire && do_rd;
   assign ram_addr      = do_wr ? tail_ff : head_ff;
   assign step.status   = status;
   assign step.is_read  = do_rd;
   assign step.is_empty = step_none;
   assign step.is_full  = !step_none && (step_head == step_tail);

   always_comb begin
      cap_in  = cap_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      none_in = none_ff;
      if (csr_wr_en) begin
         // new capacity empties the queue
         cap_in  = csr_wr_data;
         head_in = '0;
         tail_in = '0;
         none_in = 1'b1;
      end else if (fire) begin
         head_in = step_head;
         tail_in = step_tail;
         none_in = step_none;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         head_ff <= '0;
         tail_ff <= '0;
         none_ff <= 1'b1;
      end else begin
         cap_ff  <= cap_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         none_ff <= none_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/circular_fifo_queue.sv =====
// circular_fifo_queue: top level of the ring-buffer queue of signed words.
// Depends on cfq_pkg, cfq_ctrl (pointers, decode) and cfq_ram (slot memory).
//
// usage
// - req channel: one beat is one request, req_kind 0 enqueue req_value,
//   1 dequeue the head word, 2 (and 3) peek the head word
// - rsp channel: exactly one beat per request, in order: status (ok, full,
//   empty), data (head word, or all ones on enqueue and on an empty read),
//   and the empty/full flags as they stand after the request
// - csr port: csr_wr_data is the capacity, saturated into 2..DEPTH; a write
//   empties the queue; write only while no request is outstanding
// - timing: an enqueue, a rejected request or an empty read answers in the
//   cycle after its beat; a dequeue or peek passes first through the
//   registered read of the single-port slot memory, then the response register
// - throughput: one beat per cycle for writes while rsp_stall is low;
//   req_stall holds while a memory read is outstanding
// - the response sits in an output register, so a new request is taken in
//   the same cycle that a waiting response beat leaves
// - rsp_stall: the response register holds; req_stall rises until it drains
// - reset: queue empty, capacity 16 (saturated to DEPTH), no response pending;
//   slot contents are not cleared, only written slots are ever read
`default_nettype none

module circular_fifo_queue
   import cfq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [CAP_W-1:0]         csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [KIND_W-1:0]        req_kind,
   input  wire logic signed [WORD_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STAT_W-1:0]             rsp_status,
   output logic signed [WORD_W-1:0]      rsp_data,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                     fire;
   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_addr;
   logic signed [WORD_W-1:0] ram_rd_data;
   cfq_step_type             step;

   // response register and read-in-flight interlock
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     pend_ff, pend_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic signed [WORD_W-1:0] data_ff, data_in;
   logic                     empty_ff, empty_in;
   logic                     full_ff, full_in;

   // no new beat while a read is in flight or the response is stuck
   assign req_stall = pend_ff || (rsp_valid_ff && rsp_stall);
   assign fire      = req_valid && !req_stall;

   cfq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .kind        (req_kind),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_en   (ram_rd_en),
      .ram_addr    (ram_addr),
      .step        (step)
   );

   cfq_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (req_value),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pend_in      = 1'b0;
      status_in    = status_ff;
      data_in      = data_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff) begin
         // memory word arrives, status and flags were captured at the beat
         data_in      = ram_rd_data;
         rsp_valid_in = 1'b1;
      end else if (fire) begin
         status_in = step.status;
         empty_in  = step.is_empty;
         full_in   = step.is_full;
         data_in   = NO_WORD;
         if (step.is_read) begin
            pend_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      empty_ff  <= empty_in;
      full_ff   <= full_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_data     = data_ff;
   assign rsp_is_empty = empty_ff;
   assign rsp_is_full  = full_ff;

endmodule

`default_nettype wire

// ===== hdl/cfq_checker.sv =====
// cfq_port_props: port-level checks on the circular fifo queue, bound to the
// top level below. Depends on cfq_pkg for status codes.
`default_nettype none

module cfq_port_props
   import cfq_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [STAT_W-1:0]        rsp_status,
   input wire logic signed [WORD_W-1:0] rsp_data,
   input wire logic                     rsp_is_empty,
   input wire logic                     rsp_is_full
);

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)
                                 && $stable(rsp_status))
   else $error("stalled response beat changed");

   // taken request leads to a response beat or a read in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid || req_stall)
   else $error("request beat left no trace");

   // queue cannot be empty and full at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
   else $error("response flags empty and full together");

   // empty read leaves the queue empty and returns all ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_is_empty && (rsp_data == NO_WORD))
   else $error("empty status without empty flag or with data");

   // rejected enqueue leaves the queue full and returns all ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_is_full && (rsp_data == NO_WORD))
   else $error("full status without full flag or with data");

endmodule

bind circular_fifo_queue cfq_port_props u_cfq_port_props (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_data     (rsp_data),
   .rsp_is_empty (rsp_is_empty),
   .rsp_is_full  (rsp_is_full)
);

`default_nettype wire

// ===== bench/cfq_checker.sv =====
// cfq_checker: watches the request, response and csr ports of the circular fifo
// queue, keeps its own copy of the queue and compares every response beat.
// Depends on cfq_pkg for widths, request kinds and status codes.
module cfq_checker
   import cfq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [STAT_W-1:0]        rsp_status,
   input  logic signed [WORD_W-1:0] rsp_data,
   input  logic                     rsp_is_empty,
   input  logic                     rsp_is_full,
   output int                       mismatches,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [WORD_W-1:0] data;
      logic                     is_empty;
      logic                     is_full;
   } answer_type;

   // shadow queue
   logic signed [WORD_W-1:0] slot_words [DEPTH];
   int                       head_slot;
   int                       tail_slot;
   bit                       drained;
   logic [CAP_W-1:0]         cap_setting;
   answer_type               answers_due [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // capacity register saturates into 2..DEPTH
   function automatic int slots_in_use();
      int c;
      c = int'(cap_setting);
      if (c < CAP_MIN) c = CAP_MIN;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic int next_slot(input int idx);
      return (idx + 1 >= slots_in_use()) ? 0 : idx + 1;
   endfunction

   function automatic bit at_capacity();
      return !drained && head_slot == tail_slot;
   endfunction

   task automatic serve_request(input logic [KIND_W-1:0] kind,
                                input logic signed [WORD_W-1:0] word,
                                output answer_type ans);
      ans.status = ST_OK;
      ans.data   = NO_WORD;
      if (kind == KIND_ENQ) begin
         if (at_capacity()) begin
            ans.status = ST_FULL;
         end else begin
            slot_words[tail_slot] = word;
            tail_slot = next_slot(tail_slot);
            drained = 1'b0;
         end
      end else if (drained) begin
         ans.status = ST_EMPTY;
      end else begin
         // peek and the spare kind leave the head in place
         ans.data = slot_words[head_slot];
         if (kind == KIND_DEQ) begin
            head_slot = next_slot(head_slot);
            if (head_slot == tail_slot) drained = 1'b1;
         end
      end
      ans.is_empty = drained;
      ans.is_full  = at_capacity();
   endtask

   always @(posedge clock) begin
      answer_type due;
      int         errs;
      errs = 0;
      if (reset) begin
         head_slot   = 0;
         tail_slot   = 0;
         drained     = 1'b1;
         cap_setting = CAP_RESET;
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("response beat with none due: status %0d data %0d",
                      rsp_status, rsp_data);
               errs++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  errs++;
               end
               if (rsp_data !== due.data) begin
                  $error("data: expected %0d, got %0d", due.data, rsp_data);
                  errs++;
               end
               if (rsp_is_empty !== due.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", due.is_empty, rsp_is_empty);
                  errs++;
               end
               if (rsp_is_full !== due.is_full) begin
                  $error("is_full: expected %0d, got %0d", due.is_full, rsp_is_full);
                  errs++;
               end
            end
         end
         // a capacity write empties the queue
         if (csr_wr_en) begin
            cap_setting = csr_wr_data;
            head_slot   = 0;
            tail_slot   = 0;
            drained     = 1'b1;
         end
         if (req_valid && !req_stall) begin
            serve_request(req_kind, req_value, due);
            answers_due.push_back(due);
         end
      end
      mismatches  <= mismatches + errs;
      outstanding <= answers_due.size();
   end

endmodule

// ===== bench/tb_circular_fifo_queue.sv =====
// tb_circular_fifo_queue: drives requests and capacity writes into the circular
// fifo queue with random gaps and stalls, and gives the verdict.
// Depends on cfq_pkg, circular_fifo_queue and cfq_checker.
module tb_circular_fifo_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import cfq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int PHASES       = 10;
   localparam int RANDOM_ITEMS = 1600;
   // watchdog limit, with lots of room above the worst case run length
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum {FILL_UP, DRAIN_OUT, STIR} burst_mode_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     csr_wr_en   = 1'b0;
   logic [CAP_W-1:0]         csr_wr_data = '0;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind    = KIND_ENQ;
   logic signed [WORD_W-1:0] req_value   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [WORD_W-1:0] rsp_data;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   int mismatches;
   int outstanding;
   int cycle_count = 0;

   // receiver side idling
   int stall_left = 0;
   bit quiet_recv = 1'b0;

   // sender side idling, owned by the stimulus process only
   bit quiet_send = 1'b0;

   logic signed [WORD_W-1:0] corner_words [4] =
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF};
   logic [KIND_W-1:0] every_kind [4] = '{KIND_ENQ, KIND_DEQ, KIND_PEEK, KIND_RSV};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   circular_fifo_queue #(.DEPTH(DEPTH)) u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full)
   );

   cfq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full),
      .mismatches   (mismatches),
      .outstanding  (outstanding)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response stall: after each accepted beat stall at random, so the
   // stall also lands on cycles where the block is still reading its memory
   always @(posedge clock) begin
      int draw;
      if (rsp_valid && !rsp_stall) begin
         draw = quiet_recv ? 0 : $urandom_range(4);
         rsp_stall  <= (draw != 0);
         stall_left <= (draw > 0) ? draw - 1 : 0;
         // now and then switch into or out of a stretch with no stalls
         if ($urandom_range(31) == 0) quiet_recv <= !quiet_recv;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // mostly random words, about one in eight a corner value
   function automatic logic signed [WORD_W-1:0] rand_word();
      int pick;
      if ($urandom_range(7) == 0) begin
         pick = $urandom_range(3);
         return corner_words[pick];
      end
      return $urandom;
   endfunction

   // one request beat: optional random gap, then hold until taken
   task automatic issue_request(input logic [KIND_W-1:0] kind,
                                input logic signed [WORD_W-1:0] word);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= word;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and let every due response come back before going on
   task automatic settle_queue();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   // capacity writes only land on an idle queue
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      settle_queue();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [CAP_W-1:0] cap_plan [PHASES];
      burst_mode_type   mode;
      logic [KIND_W-1:0] kind;
      int               burst;
      int               sent;
      int               roll;

      // extremes of the register first: all ones, below the floor, the floor and
      // one above, the built depth and just above it, zero, 9, then two random ones
      cap_plan = '{5'd31, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd0, 5'd9, 5'd0, 5'd0};
      cap_plan[8] = CAP_W'($urandom_range(31));
      cap_plan[9] = CAP_W'($urandom_range(31));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part at the reset capacity ----
      // reads of an empty queue, including the spare kind
      issue_request(KIND_DEQ, rand_word());
      issue_request(KIND_PEEK, rand_word());
      issue_request(KIND_RSV, rand_word());
      // extreme words in, then peek both ways and drain past empty
      issue_request(KIND_ENQ, 32'sh7FFF_FFFF);
      issue_request(KIND_ENQ, 32'sh8000_0000);
      issue_request(KIND_ENQ, 32'sh0000_0000);
      issue_request(KIND_ENQ, 32'shFFFF_FFFF);
      issue_request(KIND_PEEK, rand_word());
      issue_request(KIND_RSV, rand_word());
      repeat (5) issue_request(KIND_DEQ, rand_word());

      // ---- directed part at the smallest capacity ----
      // a zero write saturates to two slots: fill, reject, wrap, drain
      set_capacity(5'd0);
      issue_request(KIND_ENQ, 32'sh5555_5555);
      issue_request(KIND_ENQ, 32'shAAAA_AAAA);
      issue_request(KIND_ENQ, rand_word());
      issue_request(KIND_PEEK, rand_word());
      issue_request(KIND_DEQ, rand_word());
      issue_request(KIND_ENQ, rand_word());
      issue_request(KIND_ENQ, rand_word());
      repeat (3) issue_request(KIND_DEQ, rand_word());

      // ---- random part ----
      // bursts that lean toward filling or draining so the queue swings
      // between full and empty and the pointers wrap at every capacity
      for (int p = 0; p < PHASES; p++) begin
         set_capacity(cap_plan[p]);
         sent = 0;
         while (sent < RANDOM_ITEMS / PHASES) begin
            burst      = $urandom_range(1, 2 * DEPTH);
            mode       = burst_mode_type'($urandom_range(2));
            quiet_send = ($urandom_range(3) == 0);
            repeat (burst) begin
               roll = $urandom_range(99);
               case (mode)
                  FILL_UP: begin
                     if (roll < 85) kind = KIND_ENQ;
                     else if (roll < 93) kind = KIND_DEQ;
                     else kind = $urandom_range(1) ? KIND_PEEK : KIND_RSV;
                  end
                  DRAIN_OUT: begin
                     if (roll < 15) kind = KIND_ENQ;
                     else if (roll < 75) kind = KIND_DEQ;
                     else kind = $urandom_range(1) ? KIND_PEEK : KIND_RSV;
                  end
                  default: begin
                     kind = every_kind[$urandom_range(3)];
                  end
               endcase
               issue_request(kind, rand_word());
               sent++;
            end
         end
      end

      // ---- wind down ----
      settle_queue();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
